// ===== rtl/core/ppst_pkg.sv =====
// shared types and constants of the pure-pursuit steering block
package ppst_pkg;

  // operation codes carried in the input tuser
  localparam logic [1:0] OP_CLEAR    = 2'd0;
  localparam logic [1:0] OP_APPEND   = 2'd1;
  localparam logic [1:0] OP_POSE     = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  // configuration register indexes
  localparam logic REG_LOOKAHEAD = 1'b0;
  localparam logic REG_GAIN      = 1'b1;

  // register reset values
  localparam logic [15:0] LOOKAHEAD_RESET = 16'd4096;
  localparam logic [15:0] GAIN_RESET      = 16'd1638;

  // steering clamp, 0.41 rad in q2.14
  localparam logic [12:0] STEER_LIMIT = 13'd6717;
  localparam logic [12:0] STEER_OVER  = 13'd6718;

  // nearest search bound, 10000 m squared in q.24
  localparam logic [50:0] NEAR_LIMIT = 51'd1677721600000000;

  // car-frame coordinate and squared length widths
  localparam int CAR_W  = 28;
  localparam int DIST_W = 57;

  // result of one car-frame transform
  typedef struct packed {
    logic                      valid;
    logic signed [CAR_W-1:0]   ty;
    logic        [DIST_W-1:0]  dist2;
  } xf_res_t;

endpackage

// ===== rtl/core/ppst_xform.sv =====
// pipelined rotation of one waypoint into the car frame, with squared length
module ppst_xform (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic signed [23:0]  wx,
  input  logic signed [23:0]  wy,
  input  logic signed [23:0]  px,
  input  logic signed [23:0]  py,
  input  logic signed [32:0]  c,
  input  logic signed [32:0]  s,
  output ppst_pkg::xf_res_t   res
);
  import ppst_pkg::*;

  logic                     v0, v1, v2, v3, v4;
  logic signed [24:0]       dx, dy;
  logic signed [57:0]       p_cx, p_sy, p_cy, p_sx;
  logic signed [58:0]       sum_x, sum_y;
  logic signed [CAR_W-1:0]  tx, ty2, ty3;
  logic signed [55:0]       sqx, sqy;
  logic signed [CAR_W-1:0]  ty_out;
  logic        [DIST_W-1:0] dist2;

  // valid bits of the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // rotated sums, floor-shifted in the datapath below
  assign sum_x = 59'(p_cx) + 59'(p_sy);
  assign sum_y = 59'(p_cy) - 59'(p_sx);

  // datapath: difference, products, shift, squares, length
  always_ff @(posedge clk) begin
    dx     <= 25'(wx) - 25'(px);
    dy     <= 25'(wy) - 25'(py);
    p_cx   <= 58'(c) * 58'(dx);
    p_sy   <= 58'(s) * 58'(dy);
    p_cy   <= 58'(c) * 58'(dy);
    p_sx   <= 58'(s) * 58'(dx);
    tx     <= CAR_W'(sum_x >>> 30);
    ty2    <= CAR_W'(sum_y >>> 30);
    sqx    <= 56'(tx) * 56'(tx);
    sqy    <= 56'(ty2) * 56'(ty2);
    ty3    <= ty2;
    dist2  <= DIST_W'($unsigned(sqx)) + DIST_W'($unsigned(sqy));
    ty_out <= ty3;
  end

  assign res.valid = v4;
  assign res.ty    = ty_out;
  assign res.dist2 = dist2;

endmodule

// ===== rtl/core/pure_pursuit_steering.sv =====
// pure-pursuit steering: waypoint table, nearest search, lookahead advance, steering
//
// channel  dir  handshake            payload
// s_*      in   s_tvalid/s_tready    tuser: operation; tdata: pos_x pos_y quat_z quat_w
// m_*      out  m_tvalid/m_tready    tdata: steering target_index; tlast: end_reached
// cfg_*    in   cfg_we               cfg_index, cfg_data
//
// clear and append are taken in idle; an empty-table pose goes straight to the output stage.
// a pose runs the nearest search over the n stored waypoints when one is due, then steps
// forward waypoint by waypoint; the memory read and the five-stage transform set each step,
// and the 13-step divide, skipped for a zero or clamped result, sets the tail.
// reset is synchronous; the waypoint memory is not cleared.
// a pending result sits in the output register while the next item is taken.
module pure_pursuit_steering #(
  parameter int MAX_WAYPOINTS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // pos_x[23:0], pos_y[47:24], quat_z[63:48], quat_w[79:64]
  input  logic [1:0]  s_tuser,   // operation[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // steering[13:0], target_index[23:14]
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import ppst_pkg::*;

  localparam int AW = $clog2(MAX_WAYPOINTS);
  localparam int CW = $clog2(MAX_WAYPOINTS + 1);

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_QUAT     = 15'b000000000000010,
    S_TRIG     = 15'b000000000000100,
    S_SEARCH   = 15'b000000000001000,
    S_ADV_TEST = 15'b000000000010000,
    S_ADV_RD   = 15'b000000000100000,
    S_ADV_XF   = 15'b000000001000000,
    S_STR_RD1  = 15'b000000010000000,
    S_STR_XF1  = 15'b000000100000000,
    S_STR_RD2  = 15'b000001000000000,
    S_STR_XF2  = 15'b000010000000000,
    S_MUL      = 15'b000100000000000,
    S_DIVCHK   = 15'b001000000000000,
    S_DIV      = 15'b010000000000000,
    S_FIN      = 15'b100000000000000
  } state_t;

  state_t state;

  // configuration
  logic [15:0] lookahead, gain;

  // table state
  logic signed [23:0] wx_mem [MAX_WAYPOINTS];
  logic signed [23:0] wy_mem [MAX_WAYPOINTS];
  logic signed [23:0] wx_q, wy_q;
  logic [AW-1:0]      rd_addr;
  logic [CW-1:0]      count;
  logic [AW-1:0]      cur;
  logic               need;

  // pose registers
  logic signed [23:0] px, py;
  logic signed [15:0] qz, qw;
  logic signed [31:0] ww, zz, wz;
  logic [31:0]        l2;
  logic signed [32:0] c, s;

  // search pipeline
  logic [CW-1:0]      scnt;
  logic               iss, v1, v2, v3;
  logic [AW-1:0]      si1, si2, si3;
  logic signed [24:0] dx2, dy2;
  logic signed [49:0] sqx, sqy;
  logic [50:0]        sd;
  logic [AW-1:0]      best;
  logic [50:0]        bestd;
  logic               closer;

  // transform and steering
  logic               xin_go;
  xf_res_t            xf;
  logic signed [CAR_W-1:0] ay;
  logic signed [CAR_W:0]   ysum;
  logic [CAR_W:0]     mag;
  logic [58:0]        num, rem, dv;
  logic [44:0]        lim;
  logic [12:0]        q;
  logic [3:0]         dk;
  logic [13:0]        res_steer;
  logic               res_end;
  logic [AW-1:0]      res_tgt;
  logic [AW-1:0]      i1, i2;
  logic [CW-1:0]      last_idx;
  logic [AW+9:0]      tgt_ext;
  logic [1:0]         op;

  assign op       = s_tuser;
  assign s_tready = (state == S_IDLE);
  assign last_idx = count - CW'(1);
  assign i1       = (cur >= AW'(2)) ? cur - AW'(2) : '0;
  assign i2       = (cur >= AW'(1)) ? cur - AW'(1) : '0;
  assign iss      = (state == S_SEARCH) && (scnt < count);
  assign sd       = 51'($unsigned(sqx)) + 51'($unsigned(sqy));
  assign closer   = (sd < bestd);
  assign mag      = ysum[CAR_W] ? (CAR_W+1)'(-ysum) : (CAR_W+1)'(ysum);
  assign dv       = 59'(l2) << dk;
  assign tgt_ext  = {10'b0, res_tgt};

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      lookahead <= LOOKAHEAD_RESET;
      gain      <= GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOOKAHEAD: lookahead <= cfg_data;
        REG_GAIN:      gain      <= cfg_data;
        default:       lookahead <= lookahead;
      endcase
    end
  end

  // read address of the waypoint memory
  always_comb begin
    case (state)
      S_SEARCH:  rd_addr = scnt[AW-1:0];
      S_STR_RD1: rd_addr = i1;
      S_STR_RD2: rd_addr = i2;
      default:   rd_addr = cur;
    endcase
  end

  // waypoint memory, appended at the fill count
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid && op == OP_APPEND &&
        count < CW'(MAX_WAYPOINTS)) begin
      wx_mem[count[AW-1:0]] <= s_tdata[23:0];
      wy_mem[count[AW-1:0]] <= s_tdata[47:24];
    end
    wx_q <= wx_mem[rd_addr];
    wy_q <= wy_mem[rd_addr];
  end

  // search pipeline valid bits and the transform start
  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      v3     <= 1'b0;
      xin_go <= 1'b0;
    end else begin
      v1     <= iss;
      v2     <= v1;
      v3     <= v2;
      xin_go <= (state == S_ADV_RD) || (state == S_STR_RD1) || (state == S_STR_RD2);
    end
  end

  // search pipeline data: map-frame difference and squares
  always_ff @(posedge clk) begin
    si1 <= scnt[AW-1:0];
    si2 <= si1;
    si3 <= si2;
    dx2 <= 25'(wx_q) - 25'(px);
    dy2 <= 25'(wy_q) - 25'(py);
    sqx <= 50'(dx2) * 50'(dx2);
    sqy <= 50'(dy2) * 50'(dy2);
  end

  // shared car-frame transform
  ppst_xform u_xform (
    .clk      (clk),
    .rst      (rst),
    .in_valid (xin_go),
    .wx       (wx_q),
    .wy       (wy_q),
    .px       (px),
    .py       (py),
    .c        (c),
    .s        (s),
    .res      (xf)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      cur      <= '0;
      need     <= 1'b1;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_FIN) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            px <= s_tdata[23:0];
            py <= s_tdata[47:24];
            qz <= s_tdata[63:48];
            qw <= s_tdata[79:64];
            case (op)
              OP_CLEAR: begin
                count <= '0;
                cur   <= '0;
                need  <= 1'b1;
              end
              OP_APPEND: begin
                if (count < CW'(MAX_WAYPOINTS)) begin
                  count <= count + CW'(1);
                end
              end
              OP_POSE: begin
                if (count == '0) begin
                  res_steer <= '0;
                  res_end   <= 1'b1;
                  res_tgt   <= '0;
                  state     <= S_FIN;
                end else begin
                  state <= S_QUAT;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_QUAT: begin
          ww    <= 32'(qw) * 32'(qw);
          zz    <= 32'(qz) * 32'(qz);
          wz    <= 32'(qw) * 32'(qz);
          l2    <= 32'(lookahead) * 32'(lookahead);
          state <= S_TRIG;
        end
        S_TRIG: begin
          c       <= 33'(ww) - 33'(zz);
          s       <= 33'(wz) <<< 1;
          res_end <= 1'b0;
          scnt    <= '0;
          best    <= '0;
          bestd   <= NEAR_LIMIT;
          if (need) begin
            state <= S_SEARCH;
          end else begin
            if (CW'(cur) > last_idx) begin
              cur <= last_idx[AW-1:0];
            end
            state <= S_ADV_TEST;
          end
        end
        S_SEARCH: begin
          if (iss) begin
            scnt <= scnt + CW'(1);
          end
          if (v3) begin
            if (closer) begin
              best  <= si3;
              bestd <= sd;
            end
            if (CW'(si3) == last_idx) begin
              cur   <= closer ? si3 : best;
              need  <= 1'b0;
              state <= S_ADV_TEST;
            end
          end
        end
        S_ADV_TEST: begin
          if (CW'(cur) + CW'(1) >= count) begin
            res_end <= 1'b1;
            need    <= 1'b1;
            state   <= S_STR_RD1;
          end else begin
            state <= S_ADV_RD;
          end
        end
        S_ADV_RD: state <= S_ADV_XF;
        S_ADV_XF: begin
          if (xf.valid) begin
            cur <= cur + AW'(1);
            if (xf.dist2 > DIST_W'(l2)) begin
              state <= S_STR_RD1;
            end else begin
              state <= S_ADV_TEST;
            end
          end
        end
        S_STR_RD1: begin
          res_tgt <= cur;
          state   <= S_STR_XF1;
        end
        S_STR_XF1: begin
          if (xf.valid) begin
            ay    <= xf.ty;
            state <= S_STR_RD2;
          end
        end
        S_STR_RD2: state <= S_STR_XF2;
        S_STR_XF2: begin
          if (xf.valid) begin
            ysum  <= (CAR_W+1)'(ay) + (CAR_W+1)'(xf.ty);
            state <= S_MUL;
          end
        end
        S_MUL: begin
          num   <= 59'(45'(gain) * 45'(mag)) << 14;
          lim   <= 45'(l2) * 45'(STEER_OVER);
          state <= S_DIVCHK;
        end
        S_DIVCHK: begin
          rem <= num;
          q   <= '0;
          dk  <= 4'd12;
          if (mag == '0) begin
            res_steer <= '0;
            state     <= S_FIN;
          end else if (num >= 59'(lim)) begin
            res_steer <= ysum[CAR_W] ? -14'({1'b0, STEER_LIMIT}) : 14'({1'b0, STEER_LIMIT});
            state     <= S_FIN;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem >= dv) begin
            rem   <= rem - dv;
            q[dk] <= 1'b1;
          end
          if (dk == 4'd0) begin
            state <= S_FIN;
            if (rem >= dv) begin
              res_steer <= ysum[CAR_W] ? -14'({1'b0, q | 13'd1}) : 14'({1'b0, q | 13'd1});
            end else begin
              res_steer <= ysum[CAR_W] ? -14'({1'b0, q}) : 14'({1'b0, q});
            end
          end else begin
            dk <= dk - 4'd1;
          end
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {tgt_ext[9:0], res_steer};
            m_tlast  <= res_end;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // steering stays inside the clamp
  a_steer_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[13:0]) <= 14'sd6717 &&
                  $signed(m_tdata[13:0]) >= -14'sd6717))
    else $error("steering outside clamp");

  // fill count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_WAYPOINTS))
    else $error("waypoint count overflow");

  // search results only arrive while searching
  a_search_stage: assert property (@(posedge clk) disable iff (rst)
    v3 |-> state == S_SEARCH)
    else $error("search stage valid outside search");

  // a stalled result is not overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("pending result changed");

endmodule

// ===== test/ppst_checker.sv =====
// checker for the pure-pursuit steering block: tracks the waypoint table and compares results
module ppst_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [79:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  input  logic        m_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int          fails,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ppst_pkg::*;

  localparam int WP_DEPTH = 1024;
  localparam longint NEAR_SQ = 64'sd1677721600000000;
  localparam longint CLAMP = 64'sd6717;

  typedef struct packed {
    logic [13:0] steering;
    logic        end_reached;
    logic [9:0]  target_index;
  } steer_cmd_t;

  // tracked block state
  logic signed [23:0] wp_x [WP_DEPTH];
  logic signed [23:0] wp_y [WP_DEPTH];
  int unsigned wp_count;
  int unsigned cur_idx;
  bit          search_due;
  logic [15:0] la_reg;
  logic [15:0] gain_reg;
  steer_cmd_t  cmd_q[$];

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fails++;
  endtask

  // rotate a stored waypoint into the car frame
  function automatic void car_frame(input int unsigned i, input longint px, input longint py,
                                    input longint c, input longint s,
                                    output longint tx, output longint ty);
    longint dx, dy;
    dx = longint'(wp_x[i]) - px;
    dy = longint'(wp_y[i]) - py;
    tx = (c * dx + s * dy) >>> 30;
    ty = (c * dy - s * dx) >>> 30;
  endfunction

  // steering command for one pose, updating the tracked index
  function automatic steer_cmd_t pose_cmd(input longint px, input longint py,
                                          input longint qz, input longint qw);
    steer_cmd_t r;
    longint c, s, l2, d, bestd, dx, dy, tx, ty, ax, ay, bx, by, ysum, mag, st;
    int unsigned best, idx, i1, i2;
    bit at_end;
    r = '0;
    if (wp_count == 0) begin
      r.end_reached = 1'b1;
      return r;
    end
    c = qw * qw - qz * qz;
    s = 2 * qw * qz;
    l2 = longint'(la_reg) * longint'(la_reg);
    if (search_due) begin
      best = 0;
      bestd = NEAR_SQ;
      for (int unsigned i = 0; i < wp_count; i++) begin
        dx = longint'(wp_x[i]) - px;
        dy = longint'(wp_y[i]) - py;
        d = dx * dx + dy * dy;
        if (d < bestd) begin
          best = i;
          bestd = d;
        end
      end
      cur_idx = best;
      search_due = 0;
    end
    idx = (cur_idx > wp_count - 1) ? wp_count - 1 : cur_idx;
    at_end = 0;
    // step forward until a waypoint lies beyond the lookahead or the table end is reached
    forever begin
      if (idx + 1 >= wp_count) begin
        at_end = 1;
        search_due = 1;
        break;
      end
      car_frame(idx, px, py, c, s, tx, ty);
      idx++;
      if (tx * tx + ty * ty > l2) break;
    end
    cur_idx = idx;
    i2 = (idx >= 1) ? idx - 1 : 0;
    i1 = (idx >= 2) ? idx - 2 : 0;
    car_frame(i1, px, py, c, s, ax, ay);
    car_frame(i2, px, py, c, s, bx, by);
    ysum = ay + by;
    mag = (ysum < 0) ? -ysum : ysum;
    if (mag == 0) st = 0;
    else if (l2 == 0) st = CLAMP;
    else begin
      st = (longint'(gain_reg) * mag * 16384) / l2;
      if (st > CLAMP) st = CLAMP;
    end
    if (ysum < 0) st = -st;
    r.steering = st[13:0];
    r.end_reached = at_end;
    r.target_index = idx[9:0];
    return r;
  endfunction

  always @(posedge clk) begin
    steer_cmd_t want;
    if (rst) begin
      wp_count = 0;
      cur_idx = 0;
      search_due = 1;
      la_reg = LOOKAHEAD_RESET;
      gain_reg = GAIN_RESET;
      cmd_q.delete();
      fails = 0;
    end else begin
      // result side first: a result can never belong to the item taken this edge
      if (m_tvalid && m_tready) begin
        if (cmd_q.size() == 0) begin
          report("unexpected result, steering", longint'(m_tdata[13:0]), 0);
        end else begin
          want = cmd_q.pop_front();
          if (m_tdata[13:0] != want.steering)
            report("steering", longint'($signed(m_tdata[13:0])),
                   longint'($signed(want.steering)));
          if (m_tlast != want.end_reached)
            report("end_reached", longint'(m_tlast), longint'(want.end_reached));
          if (m_tdata[23:14] != want.target_index)
            report("target_index", longint'(m_tdata[23:14]), longint'(want.target_index));
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_LOOKAHEAD) la_reg = cfg_data;
        else gain_reg = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        case (s_tuser)
          OP_CLEAR: begin
            wp_count = 0;
            cur_idx = 0;
            search_due = 1;
          end
          OP_APPEND: begin
            if (wp_count < WP_DEPTH) begin
              wp_x[wp_count] = s_tdata[23:0];
              wp_y[wp_count] = s_tdata[47:24];
              wp_count++;
            end
          end
          OP_POSE: begin
            cmd_q = {cmd_q, pose_cmd(longint'($signed(s_tdata[23:0])),
                                     longint'($signed(s_tdata[47:24])),
                                     longint'($signed(s_tdata[63:48])),
                                     longint'($signed(s_tdata[79:64])))};
          end
          default: ;
        endcase
      end
    end
    pending = cmd_q.size();
  end

endmodule

// ===== test/tb.sv =====
// top of the pure-pursuit steering testbench: stimulus, configuration and verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ppst_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [79:0] s_tdata;   // pos_x[23:0], pos_y[47:24], quat_z[63:48], quat_w[79:64]
  logic [1:0]  s_tuser;   // operation[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // steering[13:0], target_index[23:14]
  logic        m_tlast;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;
  int          fails;
  int          pending;

  bit idling = 1;
  int sent = 0;
  int m_hold = 0;

  pure_pursuit_steering dut (.*);

  ppst_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // result side stalls in random bursts while idling is set
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b1;
      m_hold <= 0;
    end else if (m_hold > 0) begin
      m_hold <= m_hold - 1;
      m_tready <= (m_hold == 1);
    end else if (idling && $urandom_range(0, 5) == 0) begin
      m_hold <= $urandom_range(1, 7);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // one item on the input stream, with an occasional idle burst in front while idling is set
  task automatic send(input logic [1:0] op, input logic [23:0] x, input logic [23:0] y,
                      input logic [15:0] qz, input logic [15:0] qw);
    if (idling && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {qw, qz, y, x};
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    sent++;
  endtask

  task automatic quiesce();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    quiesce();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [23:0] q12(input real m);
    return 24'(int'(m * 4096.0));
  endfunction

  // clear, lay down a gently curving path, then drive along it
  task automatic run_path(input int npts, input int nposes);
    real x0, y0, hd, stepm, x, y, ang;
    real px[$], py[$], ph[$];
    int j;
    x0 = $urandom_range(0, 1600) - 800.0;
    y0 = $urandom_range(0, 1600) - 800.0;
    hd = $urandom_range(0, 628) / 100.0;
    stepm = $urandom_range(3, 30) / 10.0;
    x = x0;
    y = y0;
    send(OP_CLEAR, 24'($urandom), 24'($urandom), 16'($urandom), 16'($urandom));
    for (int i = 0; i < npts; i++) begin
      px = {px, x};
      py = {py, y};
      ph = {ph, hd};
      send(OP_APPEND, q12(x), q12(y), 16'($urandom), 16'($urandom));
      hd += ($urandom_range(0, 40) - 20.0) / 100.0;
      x += stepm * $cos(hd);
      y += stepm * $sin(hd);
    end
    j = 0;
    for (int p = 0; p < nposes; p++) begin
      ang = ph[j] + ($urandom_range(0, 60) - 30.0) / 100.0;
      send(OP_POSE,
           q12(px[j] + ($urandom_range(0, 100) - 50.0) / 100.0),
           q12(py[j] + ($urandom_range(0, 100) - 50.0) / 100.0),
           16'(int'(32767.0 * $sin(ang / 2.0))), 16'(int'(32767.0 * $cos(ang / 2.0))));
      j += $urandom_range(0, 3);
      if (j >= npts) j = $urandom_range(0, npts - 1);
    end
  endtask

  task automatic noise();
    send(2'($urandom), 24'($urandom), 24'($urandom), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_CLEAR;
    cfg_we = 1'b0;
    cfg_index = REG_LOOKAHEAD;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, unknown code, field extremes
    send(OP_POSE, 24'h7fffff, 24'h800000, 16'h8000, 16'h7fff);
    send(OP_RESERVED, 24'h123456, 24'h654321, 16'h0, 16'h0);
    send(OP_APPEND, 24'h7fffff, 24'h7fffff, 16'h0, 16'h0);
    send(OP_APPEND, 24'h800000, 24'h800000, 16'hffff, 16'hffff);
    send(OP_APPEND, 24'h000000, 24'h000000, 16'h0, 16'h0);
    send(OP_POSE, 24'h800000, 24'h7fffff, 16'h7fff, 16'h8000);
    send(OP_POSE, 24'h000000, 24'h000000, 16'h0, 16'h7fff);
    send(OP_POSE, 24'h000001, 24'hffffff, 16'h0, 16'h0);
    send(OP_POSE, 24'h7fffff, 24'h000000, 16'h8000, 16'h8000);
    send(OP_CLEAR, 24'h0, 24'h0, 16'h0, 16'h0);
    send(OP_POSE, 24'h0, 24'h0, 16'h0, 16'h7fff);
    run_path(6, 6);

    // lookahead and gain extremes, zero lookahead included
    write_reg(REG_LOOKAHEAD, 16'd0);
    write_reg(REG_GAIN, 16'hffff);
    run_path(5, 4);
    write_reg(REG_LOOKAHEAD, 16'd1);
    run_path(5, 4);
    write_reg(REG_LOOKAHEAD, 16'hffff);
    write_reg(REG_GAIN, 16'd0);
    run_path(8, 4);
    write_reg(REG_GAIN, GAIN_RESET);
    write_reg(REG_LOOKAHEAD, LOOKAHEAD_RESET);

    // long path sent back to back
    idling = 0;
    run_path(120, 6);
    idling = 1;
    quiesce();

    // random: mostly well-formed paths, some noise and config changes
    while (sent < 500) begin
      if (sent > 440) idling = 0;
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 6)) noise();
        1: begin
          write_reg(REG_LOOKAHEAD, 16'($urandom_range(1, 16384)));
          write_reg(REG_GAIN, 16'($urandom));
        end
        default: run_path($urandom_range(1, 20), $urandom_range(1, 8));
      endcase
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
